// ===== hw/rtl/ppqn_tempo_pulse_generator_assert.svh =====
// assertion macros for the tempo clock rtl
`ifndef PPQN_TEMPO_PULSE_GENERATOR_ASSERT_SVH
`define PPQN_TEMPO_PULSE_GENERATOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PTPG_ASSERT_HOLDS(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define PTPG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptpg_pkg.sv =====
`default_nettype none

package ptpg_pkg;

    // field widths
    localparam int OP_W        = 3;
    localparam int CAPTURE_W   = 32;
    localparam int PULSE_W     = 7;
    localparam int PERIOD_W    = 18;
    localparam int STEP_W      = 16;
    localparam int SRC_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 3'd1;
    localparam logic [OP_W-1:0] OP_START   = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd4;
    localparam logic [OP_W-1:0] OP_ENCODER = 3'd5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_SOURCE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FLOOR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_CEILING = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COARSE_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINE_STEP      = 3'd4;

    // clock source codes
    localparam logic [SRC_W-1:0] SRC_EXTERNAL = 2'd1;

    // reset values
    localparam logic [SRC_W-1:0]    CLOCK_SOURCE_RST   = 2'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_FLOOR_RST   = 18'd6000;
    localparam logic [PERIOD_W-1:0] PERIOD_CEILING_RST = 18'd160000;
    localparam logic [STEP_W-1:0]   COARSE_STEP_RST    = 16'd500;
    localparam logic [STEP_W-1:0]   FINE_STEP_RST      = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RST         = 18'd45000;

    // pulses that switch the outputs
    localparam logic [PULSE_W-1:0] PULSE_ASSERT  = 7'd0;
    localparam logic [PULSE_W-1:0] PULSE_RELEASE = 7'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            enc_a;
        logic            enc_b;
        logic            enc_pressed;
    } ptpg_event_t;

    typedef struct packed {
        logic                clock_gate_n;
        logic                quarter_lamp;
        logic                reset_lamp;
        logic                reset_gate_n;
        logic                transport_flag;
        logic                pulse_strobe;
        logic [PULSE_W-1:0]  pulse_index;
        logic [PERIOD_W-1:0] period_out;
        logic                running_out;
        logic                halted_out;
    } ptpg_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppqn_tempo_pulse_generator.sv =====
// path: a result passes three register stages after its input transfer (divider products, quotient, core result)
// throughput: one event per cycle sustained while m_tready accepts results, through the two-stage reciprocal
// divider for capture counts feeding the core state update
// reset: asynchronous active low; pipeline empties, clock state returns to its
// power-up values (running, gate released, reset asserted) and registers to defaults
`default_nettype none

`include "ppqn_tempo_pulse_generator_assert.svh"

module ppqn_tempo_pulse_generator #(
    parameter int PULSES_PER_QUARTER = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_tdata: capture_count[31:0], enc_a[32], enc_b[33], enc_pressed[34], zero[39:35]
    input  wire logic [ptpg_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser: opcode[2:0]
    input  wire logic [ptpg_pkg::OP_W-1:0]         s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: clock_gate_n[0], quarter_lamp[1], reset_lamp[2], reset_gate_n[3],
    // transport_flag[4], pulse_strobe[5], pulse_index[12:6], period_out[30:13],
    // running_out[31], halted_out[32], zero[39:33]
    output logic [ptpg_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [ptpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ptpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ptpg_pkg::*;

    localparam int RESULT_W = $bits(ptpg_result_t);
    localparam logic [PULSE_W-1:0] PULSE_LIMIT = PULSE_W'(PULSES_PER_QUARTER);

    ptpg_event_t          in_event;
    ptpg_event_t          div_event;
    logic [CAPTURE_W-1:0] div_quot;
    logic                 div_valid;
    logic                 div_ready;
    ptpg_result_t         result;

    // unpack the incoming event
    assign in_event.op          = s_tuser;
    assign in_event.enc_a       = s_tdata[CAPTURE_W];
    assign in_event.enc_b       = s_tdata[CAPTURE_W+1];
    assign in_event.enc_pressed = s_tdata[CAPTURE_W+2];

    ptpg_recip_div #(
        .PULSES_PER_QUARTER (PULSES_PER_QUARTER)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_event  (in_event),
        .in_count  (s_tdata[CAPTURE_W-1:0]),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_event (div_event),
        .out_quot  (div_quot)
    );

    ptpg_core #(
        .PULSES_PER_QUARTER (PULSES_PER_QUARTER)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_event   (div_event),
        .in_quot    (div_quot),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result, last field listed in the lowest bits
    assign m_tdata = {
        (OUT_TDATA_W - RESULT_W)'(0),
        result.halted_out,
        result.running_out,
        result.period_out,
        result.pulse_index,
        result.pulse_strobe,
        result.transport_flag,
        result.reset_gate_n,
        result.reset_lamp,
        result.quarter_lamp,
        result.clock_gate_n
    };

    // pulse counter stays inside one quarter note
    `PTPG_ASSERT_HOLDS(a_pulse_range, m_tvalid, result.pulse_index < PULSE_LIMIT,
        "pulse index beyond pulses per quarter")

    // a strobe only comes from a running clock
    `PTPG_ASSERT_HOLDS(a_strobe_running, m_tvalid && result.pulse_strobe, result.running_out,
        "pulse strobe while clock stopped")

    // a new result needs an item ready at the divider output the cycle before
    `PTPG_ASSERT_HOLDS(a_result_source, m_tvalid && !$past(m_tvalid), $past(div_valid),
        "result appeared without a divider item")

    // a result held by the consumer stays presented
    `PTPG_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/ptpg_recip_div.sv =====
`default_nettype none

module ptpg_recip_div #(
    parameter int PULSES_PER_QUARTER = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ptpg_pkg::ptpg_event_t          in_event,
    input  wire logic [ptpg_pkg::CAPTURE_W-1:0] in_count,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ptpg_pkg::ptpg_event_t               out_event,
    output logic [ptpg_pkg::CAPTURE_W-1:0]      out_quot
);
    import ptpg_pkg::*;

    // exact reciprocal for a 32-bit dividend
    localparam int HALF_W      = CAPTURE_W / 2;
    localparam int LOG_D       = $clog2(PULSES_PER_QUARTER);
    localparam int RECIP_SHIFT = CAPTURE_W + LOG_D;
    localparam int RECIP_W     = CAPTURE_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PULSES_PER_QUARTER) - 64'd1) / 64'(PULSES_PER_QUARTER);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W = HALF_W + RECIP_W;
    localparam int SUM_W  = PROD_W + HALF_W + 1;

    logic                 valid_a_reg;
    logic                 valid_b_reg;
    logic                 ready_a;
    logic                 ready_b;
    logic [PROD_W-1:0]    prod_hi_reg;
    logic [PROD_W-1:0]    prod_lo_reg;
    logic [PROD_W-1:0]    prod_hi_next;
    logic [PROD_W-1:0]    prod_lo_next;
    ptpg_event_t          event_a_reg;
    ptpg_event_t          event_b_reg;
    logic [SUM_W-1:0]     sum;
    logic [CAPTURE_W-1:0] quot_reg;
    logic [CAPTURE_W-1:0] quot_next;

    // stage handshake, each stage fills when empty or draining
    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    // partial products of the two dividend halves
    assign prod_hi_next = PROD_W'(in_count[CAPTURE_W-1:HALF_W]) * PROD_W'(RECIP);
    assign prod_lo_next = PROD_W'(in_count[HALF_W-1:0]) * PROD_W'(RECIP);

    // recombine and scale down to the quotient
    assign sum       = (SUM_W'(prod_hi_reg) << HALF_W) + SUM_W'(prod_lo_reg);
    assign quot_next = CAPTURE_W'(sum >> RECIP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            event_a_reg <= in_event;
        end
        if (valid_a_reg && ready_b)
        begin
            quot_reg    <= quot_next;
            event_b_reg <= event_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_event = event_b_reg;
    assign out_quot  = quot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ptpg_core.sv =====
`default_nettype none

module ptpg_core #(
    parameter int PULSES_PER_QUARTER = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire ptpg_pkg::ptpg_event_t            in_event,
    input  wire logic [ptpg_pkg::CAPTURE_W-1:0]   in_quot,
    input  wire logic                             cfg_we,
    input  wire logic [ptpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ptpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output ptpg_pkg::ptpg_result_t                out_result
);
    import ptpg_pkg::*;

    localparam logic [PULSE_W-1:0] PULSE_LAST = PULSE_W'(PULSES_PER_QUARTER - 1);

    // configuration registers
    logic [SRC_W-1:0]    clock_source_reg;
    logic [PERIOD_W-1:0] period_floor_reg;
    logic [PERIOD_W-1:0] period_ceiling_reg;
    logic [STEP_W-1:0]   coarse_step_reg;
    logic [STEP_W-1:0]   fine_step_reg;

    // clock state
    logic [PULSE_W-1:0]  pulse_count_reg;
    logic [PULSE_W-1:0]  pulse_count_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic                running_reg;
    logic                running_next;
    logic                halted_reg;
    logic                halted_next;
    logic                gate_reg;
    logic                gate_next;
    logic                quarter_reg;
    logic                quarter_next;
    logic                lamp_reg;
    logic                lamp_next;
    logic                reset_lvl_reg;
    logic                reset_lvl_next;
    logic                transport_reg;
    logic                transport_next;
    logic                strobe;

    logic                out_valid_reg;
    ptpg_result_t        result_reg;
    ptpg_result_t        result_next;
    logic                fire;

    logic [STEP_W-1:0]    step;
    logic                 prop_en;
    logic [CAPTURE_W-1:0] prop_val;
    logic                 do_adv;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_source_reg   <= CLOCK_SOURCE_RST;
            period_floor_reg   <= PERIOD_FLOOR_RST;
            period_ceiling_reg <= PERIOD_CEILING_RST;
            coarse_step_reg    <= COARSE_STEP_RST;
            fine_step_reg      <= FINE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLOCK_SOURCE:   clock_source_reg   <= cfg_data[SRC_W-1:0];
                CFG_PERIOD_FLOOR:   period_floor_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_CEILING: period_ceiling_reg <= cfg_data[PERIOD_W-1:0];
                CFG_COARSE_STEP:    coarse_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_FINE_STEP:      fine_step_reg      <= cfg_data[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    // event decode, period proposal and pulse advance
    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        period_next      = period_reg;
        running_next     = running_reg;
        halted_next      = halted_reg;
        gate_next        = gate_reg;
        quarter_next     = quarter_reg;
        lamp_next        = lamp_reg;
        reset_lvl_next   = reset_lvl_reg;
        transport_next   = transport_reg;
        strobe           = 1'b0;
        prop_en          = 1'b0;
        prop_val         = '0;
        do_adv           = 1'b0;
        step             = in_event.enc_pressed ? fine_step_reg : coarse_step_reg;

        unique case (in_event.op)
            OP_TICK:
            begin
                do_adv = !halted_reg;
            end
            OP_CAPTURE:
            begin
                halted_next      = 1'b0;
                prop_en          = 1'b1;
                prop_val         = in_quot;
                pulse_count_next = '0;
                do_adv           = 1'b1;
            end
            OP_START:
            begin
                running_next = 1'b1;
                halted_next  = 1'b0;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
            end
            OP_RESET:
            begin
                pulse_count_next = '0;
                reset_lvl_next   = 1'b0;
                transport_next   = 1'b1;
            end
            OP_ENCODER:
            begin
                if (!in_event.enc_a && in_event.enc_b)
                begin
                    if (PERIOD_W'(step) <= period_reg)
                    begin
                        prop_en  = 1'b1;
                        prop_val = CAPTURE_W'(period_reg - PERIOD_W'(step));
                    end
                end
                else if (!in_event.enc_a && !in_event.enc_b)
                begin
                    prop_en  = 1'b1;
                    prop_val = CAPTURE_W'(period_reg) + CAPTURE_W'(step);
                end
            end
            default: ;
        endcase

        // accept a proposed period only inside the window
        if (prop_en && (prop_val >= CAPTURE_W'(period_floor_reg))
                    && (prop_val <= CAPTURE_W'(period_ceiling_reg)))
        begin
            period_next = prop_val[PERIOD_W-1:0];
        end

        // pulse advance
        if (do_adv && running_reg)
        begin
            strobe = 1'b1;
            if (pulse_count_next == PULSE_ASSERT)
            begin
                gate_next    = 1'b0;
                quarter_next = 1'b1;
                lamp_next    = 1'b1;
            end
            if (pulse_count_next == PULSE_RELEASE)
            begin
                reset_lvl_next = 1'b1;
                transport_next = 1'b0;
                gate_next      = 1'b1;
                quarter_next   = 1'b0;
                lamp_next      = 1'b0;
            end
            if (pulse_count_next < PULSE_LAST)
            begin
                pulse_count_next = pulse_count_next + 7'd1;
            end
            else if (clock_source_reg == SRC_EXTERNAL)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                pulse_count_next = '0;
            end
        end

        result_next.clock_gate_n    = gate_next;
        result_next.quarter_lamp    = quarter_next;
        result_next.reset_lamp      = lamp_next;
        result_next.reset_gate_n    = reset_lvl_next;
        result_next.transport_flag  = transport_next;
        result_next.pulse_strobe    = strobe;
        result_next.pulse_index     = pulse_count_next;
        result_next.period_out      = period_next;
        result_next.running_out     = running_next;
        result_next.halted_out      = halted_next;
    end

    // state update on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            period_reg      <= PERIOD_RST;
            running_reg     <= 1'b1;
            halted_reg      <= 1'b0;
            gate_reg        <= 1'b1;
            quarter_reg     <= 1'b0;
            lamp_reg        <= 1'b0;
            reset_lvl_reg   <= 1'b0;
            transport_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (fire)
            begin
                pulse_count_reg <= pulse_count_next;
                period_reg      <= period_next;
                running_reg     <= running_next;
                halted_reg      <= halted_next;
                gate_reg        <= gate_next;
                quarter_reg     <= quarter_next;
                lamp_reg        <= lamp_next;
                reset_lvl_reg   <= reset_lvl_next;
                transport_reg   <= transport_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire
